/* rtl/ffa_pkg.sv */
// Shared definitions for the first-fit free-list allocator.
// Holds the controller state type, status and register codes and parameter defaults.
// No dependencies.
package ffa_pkg;

  // Parameter defaults.
  localparam int DEF_MAX_EXTENTS   = 64;
  localparam int DEF_GRANULE_BYTES = 16;
  localparam int DEF_ADDR_BITS     = 32;

  // Configuration port index width and register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEAP_SIZE = 2'd1;

  // Request kinds.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STS_DONE   = 2'd0;
  localparam logic [1:0] STS_NO_FIT = 2'd1;
  localparam logic [1:0] STS_FULL   = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ROUND,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } ffa_state_t;

endpackage

/* rtl/first_fit_free_list_allocator_core.sv */
// Top level of the first-fit free-list allocator.
// Keeps the extent table in one synchronous memory; depends on ffa_pkg.
//
// Each request is one input transfer and gives one result transfer. A free is accepted in
// ST_IDLE and goes straight to ST_RESP for the result handoff. An allocate first rounds the
// request, eight bits of the size per cycle, then walks the extent table from the head through
// the single memory read port, one entry per cycle, with the entry read registered before the
// fit test. Granting a whole extent closes the gap by moving every later entry down one slot,
// one entry per cycle through the same port. The block works on one request at a time. After
// reset it writes the initial extent in ST_INIT before it takes requests. Writing heap_base or
// heap_size rebuilds the table as one extent over the heap and clears the used byte count;
// write configuration only while no request is in flight.
module first_fit_free_list_allocator_core
  import ffa_pkg::*;
#(
  parameter int MAX_EXTENTS   = DEF_MAX_EXTENTS,
  parameter int GRANULE_BYTES = DEF_GRANULE_BYTES,
  parameter int ADDR_BITS     = DEF_ADDR_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Request channel.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [95:0]             in_tdata,   // request_size, free_address, free_size
  input  logic                    in_tuser,   // operation
  // Result channel.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [95:0]             out_tdata,  // granted_address, granted_size, bytes_used
  output logic [1:0]              out_tuser,  // status
  // Configuration write channel.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data
);

  localparam int PTR_W  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int EW     = ADDR_BITS + 32;
  localparam int RW     = $clog2(GRANULE_BYTES) + 1;
  localparam int RND_STEPS = 5;
  localparam logic [2:0] RND_LAST = 3'(RND_STEPS - 1);

  // Table memory: length in the upper 32 bits, address in the lower bits.
  logic [EW-1:0] mem [MAX_EXTENTS];
  logic [EW-1:0] rd_data_r;

  ffa_state_t state_r, state_nxt;

  logic [31:0]       base_r, size_r, used_r;
  logic [PTR_W-1:0]  head_r;
  logic [CNT_W-1:0]  count_r;
  logic [32:0]       w_r, want_r;
  logic [RW-1:0]     rem_r;
  logic [2:0]        rc_r;
  logic [CNT_W-1:0]  scan_k_r, pend_k_r, sh_j_r, end_r;
  logic              pend_r, sh_pend_r;
  logic [PTR_W-1:0]  pend_pa_r, sh_pa_r;
  logic [1:0]        sts_r;
  logic [31:0]       ga_r, gs_r;

  // Maps a logical table position to its memory slot.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(k);
    if (s >= SUM_W'(MAX_EXTENTS)) s = s - SUM_W'(MAX_EXTENTS);
    return PTR_W'(s);
  endfunction

  function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(MAX_EXTENTS - 1) : p - 1'b1;
  endfunction

  logic in_xfer, out_xfer, cfg_xfer, cfg_hit;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_xfer && (cfg_index == CFG_HEAP_BASE || cfg_index == CFG_HEAP_SIZE);

  logic [31:0] req_size, fr_addr, fr_size;
  assign req_size = in_tdata[31:0];
  assign fr_addr  = in_tdata[63:32];
  assign fr_size  = in_tdata[95:64];

  // Fields of the entry read last cycle and the fit test against the rounded size.
  logic [31:0]          rd_len;
  logic [ADDR_BITS-1:0] rd_adr;
  logic [32:0]          left;
  logic                 hit, big_left, scan_fail, table_full;
  assign rd_len     = rd_data_r[EW-1:ADDR_BITS];
  assign rd_adr     = rd_data_r[ADDR_BITS-1:0];
  assign hit        = pend_r && ({1'b0, rd_len} >= want_r);
  assign left       = {1'b0, rd_len} - want_r;
  assign big_left   = left >= 33'(GRANULE_BYTES);
  assign scan_fail  = !hit && (scan_k_r >= count_r);
  assign table_full = count_r >= CNT_W'(MAX_EXTENTS);

  // Remainder of the size by the granule, eight bits per cycle from the top.
  logic [39:0]   w_ext;
  logic [7:0]    chunk;
  logic [RW-1:0] rem_nxt;
  logic [32:0]   want_calc;
  assign w_ext = {7'd0, w_r};
  assign chunk = w_ext[{3'(RND_LAST - rc_r), 3'b000} +: 8];
  always_comb begin
    logic [RW:0] r;
    r = {1'b0, rem_r};
    for (int b = 7; b >= 0; b--) begin
      r = {r[RW-1:0], chunk[b]};
      if (r >= (RW+1)'(GRANULE_BYTES)) r = r - (RW+1)'(GRANULE_BYTES);
    end
    rem_nxt = r[RW-1:0];
  end
  assign want_calc = (rem_nxt == '0) ? w_r :
                     w_r + 33'(GRANULE_BYTES) - 33'(rem_nxt);

  // Saturating counter updates.
  logic [32:0] used_add;
  logic [31:0] used_alloc, used_free, granted;
  assign granted    = big_left ? want_r[31:0] : rd_len;
  assign used_add   = {1'b0, used_r} + {1'b0, granted};
  assign used_alloc = used_add[32] ? 32'hFFFF_FFFF : used_add[31:0];
  assign used_free  = (used_r >= fr_size) ? used_r - fr_size : 32'd0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:  state_nxt = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_nxt = (in_tuser == OP_FREE) ? ST_RESP : ST_ROUND;
      ST_ROUND: if (rc_r == RND_LAST) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (hit) state_nxt = big_left ? ST_RESP : ST_SHIFT;
        else if (scan_fail) state_nxt = ST_RESP;
      end
      ST_SHIFT: if (sh_j_r >= end_r && !sh_pend_r) state_nxt = ST_RESP;
      ST_RESP:  if (out_xfer) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_RESP);
    cfg_ready  = (state_r != ST_INIT);
  end
  assign out_tdata = {used_r, gs_r, ga_r};
  assign out_tuser = sts_r;

  // Memory port control.
  logic             mem_we, rd_en;
  logic [PTR_W-1:0] mem_wa, rd_addr;
  logic [EW-1:0]    mem_wd;
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = '0;
    mem_wd  = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cfg_hit) begin
      mem_we = 1'b1;
      mem_wd = (cfg_index == CFG_HEAP_BASE) ? {size_r, ADDR_BITS'(cfg_data)}
                                            : {cfg_data, ADDR_BITS'(base_r)};
    end
    case (state_r)
      ST_INIT: mem_we = 1'b1;
      ST_IDLE: begin
        if (in_xfer && in_tuser == OP_FREE && !table_full) begin
          mem_we = 1'b1;
          mem_wa = prev_slot(head_r);
          mem_wd = {fr_size, ADDR_BITS'(fr_addr)};
        end
      end
      ST_SCAN: begin
        if (hit && big_left) begin
          mem_we = 1'b1;
          mem_wa = pend_pa_r;
          mem_wd = {left[31:0], ADDR_BITS'(rd_adr + ADDR_BITS'(want_r))};
        end
        if (!hit && scan_k_r < count_r) begin
          rd_en   = 1'b1;
          rd_addr = phys(head_r, scan_k_r);
        end
      end
      ST_SHIFT: begin
        if (sh_pend_r) begin
          mem_we = 1'b1;
          mem_wa = prev_slot(sh_pa_r);
          mem_wd = rd_data_r;
        end
        if (sh_j_r < end_r) begin
          rd_en   = 1'b1;
          rd_addr = phys(head_r, sh_j_r);
        end
      end
      default: ;
    endcase
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      base_r    <= '0;
      size_r    <= '0;
      used_r    <= '0;
      head_r    <= '0;
      count_r   <= CNT_W'(1);
      pend_r    <= 1'b0;
      sh_pend_r <= 1'b0;
      rc_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        if (cfg_index == CFG_HEAP_BASE) base_r <= cfg_data;
        else size_r <= cfg_data;
        used_r  <= '0;
        head_r  <= '0;
        count_r <= CNT_W'(1);
      end
      case (state_r)
        ST_IDLE: begin
          rc_r  <= '0;
          rem_r <= '0;
          if (in_xfer) begin
            ga_r <= '0;
            gs_r <= '0;
            w_r  <= (req_size < 32'(GRANULE_BYTES)) ? 33'(GRANULE_BYTES) : {1'b0, req_size};
            if (in_tuser == OP_FREE) begin
              used_r <= used_free;
              if (table_full) begin
                sts_r <= STS_FULL;
              end else begin
                sts_r   <= STS_DONE;
                head_r  <= prev_slot(head_r);
                count_r <= count_r + 1'b1;
              end
            end
          end
        end
        ST_ROUND: begin
          rem_r <= rem_nxt;
          rc_r  <= rc_r + 1'b1;
          if (rc_r == RND_LAST) begin
            want_r   <= want_calc;
            scan_k_r <= '0;
            pend_r   <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            pend_r <= 1'b0;
            sts_r  <= STS_DONE;
            ga_r   <= 32'(rd_adr);
            gs_r   <= granted;
            used_r <= used_alloc;
            if (!big_left) begin
              sh_j_r    <= pend_k_r + 1'b1;
              end_r     <= count_r;
              count_r   <= count_r - 1'b1;
              sh_pend_r <= 1'b0;
            end
          end else if (scan_fail) begin
            pend_r <= 1'b0;
            sts_r  <= STS_NO_FIT;
          end else begin
            pend_r    <= 1'b1;
            pend_k_r  <= scan_k_r;
            pend_pa_r <= phys(head_r, scan_k_r);
            scan_k_r  <= scan_k_r + 1'b1;
          end
        end
        ST_SHIFT: begin
          if (sh_j_r < end_r) begin
            sh_pend_r <= 1'b1;
            sh_pa_r   <= phys(head_r, sh_j_r);
            sh_j_r    <= sh_j_r + 1'b1;
          end else begin
            sh_pend_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sim/tb_first_fit_free_list_allocator_core.sv */
// Self-checking bench for the first-fit free-list allocator core.
// Predicts each result with a behavioral extent table and compares every result transfer.
// Depends on ffa_pkg and first_fit_free_list_allocator_core.
module tb_first_fit_free_list_allocator_core;
  import ffa_pkg::*;

  localparam int EXTENTS = DEF_MAX_EXTENTS;
  localparam int GRAN    = DEF_GRANULE_BYTES;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        op;
    logic [31:0] req_size;
    logic [31:0] ret_addr;
    logic [31:0] ret_size;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] used;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  first_fit_free_list_allocator_core dut (.*);

  always #1 clk = ~clk;

  // Predictor state: the free extent table and used byte count.
  logic [31:0] tbl_addr [EXTENTS];
  logic [31:0] tbl_len [EXTENTS];
  int          tbl_count;
  logic [31:0] used_bytes;
  logic [31:0] base_reg = '0, size_reg = '0;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int  mismatches = 0;
  longint cycles = 0;
  int  sent = 0, received = 0, no_fit_seen = 0, full_seen = 0;
  bit  hold_out = 1'b0;

  function automatic void rebuild_table();
    tbl_addr[0] = base_reg;
    tbl_len[0]  = size_reg;
    tbl_count   = 1;
    used_bytes  = '0;
  endfunction

  // Computes the answer to one request and updates the table.
  function automatic answer_t allocate_or_free(request_t r);
    answer_t a;
    logic [33:0] want;
    logic [32:0] sum;
    int i;
    a = '0;
    if (r.op == OP_ALLOC) begin
      want = {2'b0, r.req_size};
      if (want < GRAN) want = GRAN;
      want = (want + GRAN - 1) / GRAN * GRAN;
      for (i = 0; i < tbl_count; i++)
        if ({2'b0, tbl_len[i]} >= want) break;
      if (i >= tbl_count) begin
        a.status = STS_NO_FIT;
      end else begin
        a.status = STS_DONE;
        a.addr = tbl_addr[i];
        if ({2'b0, tbl_len[i]} - want >= GRAN) begin
          a.size = want[31:0];
          tbl_addr[i] = tbl_addr[i] + want[31:0];
          tbl_len[i]  = tbl_len[i] - want[31:0];
        end else begin
          a.size = tbl_len[i];
          for (int j = i; j < tbl_count - 1; j++) begin
            tbl_addr[j] = tbl_addr[j+1];
            tbl_len[j]  = tbl_len[j+1];
          end
          tbl_count--;
        end
        sum = {1'b0, used_bytes} + {1'b0, a.size};
        used_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end else begin
      if (tbl_count >= EXTENTS) begin
        a.status = STS_FULL;
      end else begin
        for (int j = tbl_count; j > 0; j--) begin
          tbl_addr[j] = tbl_addr[j-1];
          tbl_len[j]  = tbl_len[j-1];
        end
        tbl_addr[0] = r.ret_addr;
        tbl_len[0]  = r.ret_size;
        tbl_count++;
        a.status = STS_DONE;
      end
      used_bytes = (used_bytes >= r.ret_size) ? used_bytes - r.ret_size : '0;
    end
    a.used = used_bytes;
    return a;
  endfunction

  // Driver: offers queued requests, with a random gap after each accepted one.
  int gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(allocate_or_free(pending_reqs.pop_front()));
        sent <= sent + 1;
        in_tvalid <= 1'b0;
        gap = $urandom_range(0, 8);
      end else if (!in_tvalid && pending_reqs.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].op;
          in_tdata  <= {pending_reqs[0].ret_size, pending_reqs[0].ret_addr,
                        pending_reqs[0].req_size};
        end
      end
    end
  end

  // Monitor: checks each result transfer and draws a random stall before the next.
  int stall = 0;
  always @(posedge clk) begin
    answer_t got, exp_a;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64]};
        received <= received + 1;
        if (got.status == STS_NO_FIT) no_fit_seen <= no_fit_seen + 1;
        if (got.status == STS_FULL) full_seen <= full_seen + 1;
        if (expected_answers.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("Unexpected result transfer %p", got);
        end else begin
          exp_a = expected_answers.pop_front();
          if (got !== exp_a) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("Mismatch: expected %p, got %p", exp_a, got);
          end
        end
        out_tready <= 1'b0;
        stall = $urandom_range(0, 8);
      end else if (hold_out) begin
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Global watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (3 * EXTENTS) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_HEAP_BASE) base_reg = val; else size_reg = val;
    rebuild_table();
    @(posedge clk);
  endtask

  function automatic void add_alloc(logic [31:0] n);
    request_t r;
    r = '0;
    r.op = OP_ALLOC;
    r.req_size = n;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_free(logic [31:0] a, logic [31:0] n);
    request_t r;
    r = '0;
    r.op = OP_FREE;
    r.ret_addr = a;
    r.ret_size = n;
    pending_reqs.push_back(r);
  endfunction

  // Sizes mostly small, sometimes any 32-bit value.
  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  initial begin
    rebuild_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty heap, then a small heap near the top of the address space.
    add_alloc(0);
    add_free(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    add_alloc(32'hFFFF_FFFF);
    add_alloc(32'hFFFF_FFF1);
    add_alloc(32'hFFFF_FFE0);
    add_free(32'h0, 32'hFFFF_FFFF);
    wait_drained();
    write_register(CFG_HEAP_BASE, 32'hFFFF_FF00);
    write_register(CFG_HEAP_SIZE, 32'h0000_0200);
    add_alloc(0); add_alloc(1); add_alloc(16); add_alloc(17); add_alloc(31);
    add_free(32'h1234_5670, 0);
    add_alloc(0);
    add_alloc(32'h0000_01B0);
    add_alloc(32'h0000_0008);
    add_free(32'hFFFF_FFF0, 32'h0000_0040);
    add_alloc(32'h0000_0030);
    add_alloc(32'h0000_0FFF);
    add_free(32'h0, 32'hFFFF_FFFF);
    wait_drained();

    // Fill the table with frees to reach the full case, with a long receiver stall.
    write_register(CFG_HEAP_SIZE, 32'h0000_0100);
    hold_out = 1'b1;
    for (int i = 0; i < EXTENTS + 4; i++) add_free($urandom, $urandom_range(0, 48));
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
    wait_drained();

    // Random phases over several heap settings, including the extremes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_register(CFG_HEAP_BASE, 32'h0); write_register(CFG_HEAP_SIZE, 32'h4000); end
        1: write_register(CFG_HEAP_SIZE, 32'hFFFF_FFF0);
        2: write_register(CFG_HEAP_BASE, 32'hFFFF_FFFF);
        3: write_register(CFG_HEAP_SIZE, 32'h0);
        default: begin
          write_register(CFG_HEAP_BASE, $urandom & 32'hFFFF_FFF0);
          write_register(CFG_HEAP_SIZE, $urandom_range(16, 8192) & 32'hFFF0);
        end
      endcase
      for (int k = 0; k < 250; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          add_free($urandom, pick_size());
        end else begin
          add_alloc(pick_size());
        end
      end
      wait_drained();
    end

    $display("Covered %0d requests, %0d results: %0d no-fit and %0d table-full outcomes.",
             sent, received, no_fit_seen, full_seen);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
